@@ hdl/htok_pkg.sv @@
// Shared types, constants and character tables of the HTTP request header tokenizer.
package htok_pkg;

  localparam int unsigned CfgWidth = 8;
  localparam int unsigned CfgIndexWidth = 1;
  localparam logic [CfgWidth-1:0] QueryKeyLimitReset = 8'd63;
  localparam logic [CfgWidth-1:0] QueryValueLimitReset = 8'd191;

  localparam logic [CfgIndexWidth-1:0] CFG_QUERY_KEY_LIMIT = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_QUERY_VALUE_LIMIT = 1'd1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [3:0] {
    PH_VERB       = 4'd0,
    PH_SKIP       = 4'd1,
    PH_PATH       = 4'd2,
    PH_QKEY       = 4'd3,
    PH_QVAL       = 4'd4,
    PH_LSKIP      = 4'd5,
    PH_HLEAD      = 4'd6,
    PH_HKEY       = 4'd7,
    PH_HSEP       = 4'd8,
    PH_HVAL       = 4'd9,
    PH_HTAIL      = 4'd10,
    PH_DONE_OK    = 4'd11,
    PH_DONE_VERB  = 4'd12,
    PH_DONE_EOF   = 4'd13,
    PH_DONE_EMPTY = 4'd14
  } phase_t;

  typedef enum logic [3:0] {
    TK_NONE     = 4'd0,
    TK_PATH     = 4'd1,
    TK_QKEY     = 4'd2,
    TK_QVAL     = 4'd3,
    TK_QPAIR    = 4'd4,
    TK_HKEY     = 4'd5,
    TK_HVAL     = 4'd6,
    TK_ACCEPT   = 4'd7,
    TK_REJECT   = 4'd8,
    TK_PATH_END = 4'd9
  } token_t;

  typedef enum logic [1:0] {
    VERB_NONE  = 2'd0,
    VERB_GET   = 2'd1,
    VERB_POST  = 2'd2,
    VERB_PATCH = 2'd3
  } verb_t;

  typedef enum logic [2:0] {
    ST_BUSY  = 3'd0,
    ST_OK    = 3'd1,
    ST_VERB  = 3'd2,
    ST_EOF   = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] verb_pos;
    logic [2:0] verb_match;
    verb_t      verb_held;
    logic [1:0] skip_left;
    logic [7:0] field_len;
    logic       line_has;
    logic       query_dead;
  } tok_state_t;

  localparam tok_state_t StateReset = '{
    phase:      PH_VERB,
    verb_pos:   3'd0,
    verb_match: 3'b111,
    verb_held:  VERB_NONE,
    skip_left:  2'd0,
    field_len:  8'd0,
    line_has:   1'b0,
    query_dead: 1'b0
  };

  // Characters of the three verbs; GET has no fourth character.
  function automatic logic [7:0] verb_char(input logic [1:0] verb_sel, input logic [1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (verb_sel)
      2'd0: begin
        case (pos)
          2'd0: c = "G";
          2'd1: c = "E";
          2'd2: c = "T";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          2'd0: c = "P";
          2'd1: c = "O";
          2'd2: c = "S";
          default: c = "T";
        endcase
      end
      2'd2: begin
        case (pos)
          2'd0: c = "P";
          2'd1: c = "A";
          2'd2: c = "T";
          default: c = "C";
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic status_t phase_status(input phase_t ph);
    status_t s;
    case (ph)
      PH_DONE_OK:    s = ST_OK;
      PH_DONE_VERB:  s = ST_VERB;
      PH_DONE_EOF:   s = ST_EOF;
      PH_DONE_EMPTY: s = ST_EMPTY;
      default:       s = ST_BUSY;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/htok_step.sv @@
// Per-byte next-state and token logic of the tokenizer.
module htok_step import htok_pkg::*; (
  input  tok_state_t          st,
  input  logic [7:0]          byte_in,
  input  logic                stream_end,
  input  logic [CfgWidth-1:0] query_key_limit,
  input  logic [CfgWidth-1:0] query_value_limit,
  output tok_state_t          st_nxt,
  output token_t              token_kind,
  output logic [7:0]          token_byte
);

  logic [1:0] vpos;
  logic [2:0] vmatch;
  logic       b_ws;
  logic       b_eol;
  logic       b_cr;
  logic       key_room;
  logic       val_full;
  logic [8:0] val_next;
  logic [7:0] val_lim;
  logic       hdr_ok;
  logic       done;

  assign vpos = st.verb_pos[1:0];
  assign vmatch = st.verb_match & {byte_in == verb_char(2'd2, vpos),
                                   byte_in == verb_char(2'd1, vpos),
                                   (vpos == 2'd3) || (byte_in == verb_char(2'd0, vpos))};
  assign b_ws = (byte_in == CH_SPACE) || (byte_in == CH_TAB);
  assign b_eol = (byte_in == CH_LF) || (byte_in == CH_NUL);
  assign b_cr = (byte_in == CH_CR);
  assign key_room = st.field_len < query_key_limit;
  assign val_lim = (query_value_limit == 8'd0) ? 8'd1 : query_value_limit;
  assign val_next = {1'b0, st.field_len} + 9'd1;
  assign val_full = val_next >= {1'b0, val_lim};
  assign hdr_ok = (st.field_len != 8'd0) && ((st.phase == PH_HVAL) || (st.phase == PH_HTAIL));
  assign done = st.phase >= PH_DONE_OK;

  always_comb begin
    st_nxt = st;
    if (done) begin
      st_nxt = st;
    end else if (stream_end) begin
      st_nxt.phase = (st.phase >= PH_HLEAD) ? PH_DONE_OK : PH_DONE_EOF;
    end else if (st.phase == PH_VERB) begin
      st_nxt.verb_match = vmatch;
      st_nxt.verb_pos = {1'b0, vpos} + 3'd1;
      if (vpos == 2'd3) begin
        if (vmatch[0]) begin
          st_nxt.verb_held = VERB_GET;
          st_nxt.phase = PH_PATH;
        end else if (vmatch[1]) begin
          st_nxt.verb_held = VERB_POST;
          st_nxt.skip_left = 2'd1;
          st_nxt.phase = PH_SKIP;
        end else if (vmatch[2]) begin
          st_nxt.verb_held = VERB_PATCH;
          st_nxt.skip_left = 2'd2;
          st_nxt.phase = PH_SKIP;
        end else begin
          st_nxt.phase = PH_DONE_VERB;
        end
      end
    end else if (st.phase == PH_SKIP) begin
      if (st.skip_left != 2'd0) begin
        st_nxt.skip_left = st.skip_left - 2'd1;
      end
      if (st.skip_left <= 2'd1) begin
        st_nxt.phase = PH_PATH;
      end
    end else if (b_cr) begin
      st_nxt = st;
    end else if (st.phase == PH_PATH || st.phase == PH_QKEY || st.phase == PH_QVAL ||
                 st.phase == PH_LSKIP) begin
      if (b_eol && !(st.phase == PH_QVAL && val_full && 1'b0)) begin
        if (st.phase == PH_QKEY && st.field_len != 8'd0) begin
          st_nxt.query_dead = 1'b1;
        end
        if (!st.line_has && !(st.phase == PH_PATH && byte_in == CH_NUL)) begin
          st_nxt.phase = PH_DONE_EMPTY;
        end else begin
          st_nxt.phase = PH_HLEAD;
          st_nxt.line_has = 1'b0;
          st_nxt.field_len = 8'd0;
        end
      end else begin
        case (st.phase)
          PH_PATH: begin
            if (byte_in == CH_SPACE) begin
              st_nxt.phase = PH_LSKIP;
            end else if (byte_in == CH_QUEST) begin
              st_nxt.phase = PH_QKEY;
              st_nxt.field_len = 8'd0;
            end else begin
              st_nxt.line_has = 1'b1;
            end
          end
          PH_QKEY: begin
            if (byte_in == CH_SPACE) begin
              if (st.field_len != 8'd0) begin
                st_nxt.query_dead = 1'b1;
              end
              st_nxt.phase = PH_LSKIP;
            end else if (byte_in == CH_EQUAL) begin
              st_nxt.phase = PH_QVAL;
              st_nxt.field_len = 8'd0;
            end else if (byte_in != CH_AMP && key_room) begin
              st_nxt.field_len = st.field_len + 8'd1;
            end else begin
              st_nxt.query_dead = 1'b1;
              st_nxt.phase = PH_LSKIP;
            end
          end
          PH_QVAL: begin
            if (byte_in == CH_SPACE) begin
              st_nxt.phase = PH_LSKIP;
            end else if (byte_in == CH_AMP) begin
              st_nxt.phase = PH_QKEY;
              st_nxt.field_len = 8'd0;
            end else if (byte_in == CH_EQUAL) begin
              st_nxt.field_len = 8'd0;
            end else if (val_full) begin
              st_nxt.phase = PH_QKEY;
              st_nxt.field_len = 8'd0;
            end else begin
              st_nxt.field_len = st.field_len + 8'd1;
            end
          end
          default: begin
            st_nxt = st;
          end
        endcase
      end
    end else if (b_eol) begin
      if (byte_in == CH_LF && !st.line_has) begin
        st_nxt.phase = PH_DONE_OK;
      end else begin
        st_nxt.phase = PH_HLEAD;
        st_nxt.line_has = 1'b0;
        st_nxt.field_len = 8'd0;
      end
    end else begin
      st_nxt.line_has = 1'b1;
      case (st.phase)
        PH_HLEAD: begin
          if (byte_in == CH_COLON) begin
            st_nxt.phase = PH_HSEP;
          end else if (!b_ws) begin
            st_nxt.field_len = 8'd1;
            st_nxt.phase = PH_HKEY;
          end
        end
        PH_HKEY: begin
          if (byte_in == CH_COLON || b_ws) begin
            st_nxt.phase = PH_HSEP;
          end
        end
        PH_HSEP: begin
          if (!(byte_in == CH_COLON || b_ws)) begin
            st_nxt.phase = PH_HVAL;
          end
        end
        PH_HVAL: begin
          if (b_ws) begin
            st_nxt.phase = PH_HTAIL;
          end
        end
        default: begin
          st_nxt.line_has = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    token_kind = TK_NONE;
    token_byte = 8'h00;
    if (done) begin
      token_kind = TK_NONE;
    end else if (stream_end) begin
      token_kind = (st.phase >= PH_HLEAD) ? TK_ACCEPT : TK_REJECT;
    end else if (st.phase == PH_VERB) begin
      if (vpos == 2'd3 && vmatch == 3'b000) begin
        token_kind = TK_REJECT;
      end
    end else if (st.phase == PH_SKIP || b_cr) begin
      token_kind = TK_NONE;
    end else if (st.phase == PH_PATH || st.phase == PH_QKEY || st.phase == PH_QVAL ||
                 st.phase == PH_LSKIP) begin
      if (b_eol) begin
        if (!st.line_has && !(st.phase == PH_PATH && byte_in == CH_NUL)) begin
          token_kind = TK_REJECT;
        end else if (st.phase == PH_PATH) begin
          token_kind = TK_PATH_END;
        end else if (st.phase == PH_QVAL) begin
          token_kind = TK_QPAIR;
        end
      end else begin
        case (st.phase)
          PH_PATH: begin
            if (byte_in == CH_SPACE || byte_in == CH_QUEST) begin
              token_kind = TK_PATH_END;
            end else begin
              token_kind = TK_PATH;
              token_byte = byte_in;
            end
          end
          PH_QKEY: begin
            if (byte_in != CH_SPACE && byte_in != CH_EQUAL && byte_in != CH_AMP && key_room) begin
              token_kind = TK_QKEY;
              token_byte = byte_in;
            end
          end
          PH_QVAL: begin
            if (byte_in == CH_SPACE || byte_in == CH_AMP || byte_in == CH_EQUAL) begin
              token_kind = TK_QPAIR;
            end else if (val_full) begin
              token_kind = TK_QPAIR;
              token_byte = byte_in;
            end else begin
              token_kind = TK_QVAL;
              token_byte = byte_in;
            end
          end
          default: begin
            token_kind = TK_NONE;
          end
        endcase
      end
    end else if (b_eol) begin
      if (byte_in == CH_LF && !st.line_has) begin
        token_kind = TK_ACCEPT;
      end else if (!hdr_ok) begin
        token_kind = TK_REJECT;
      end
    end else begin
      case (st.phase)
        PH_HLEAD: begin
          if (byte_in != CH_COLON && !b_ws) begin
            token_kind = TK_HKEY;
            token_byte = byte_in;
          end
        end
        PH_HKEY: begin
          if (!(byte_in == CH_COLON || b_ws)) begin
            token_kind = TK_HKEY;
            token_byte = byte_in;
          end
        end
        PH_HSEP: begin
          if (!(byte_in == CH_COLON || b_ws)) begin
            token_kind = TK_HVAL;
            token_byte = byte_in;
          end
        end
        PH_HVAL: begin
          if (!b_ws) begin
            token_kind = TK_HVAL;
            token_byte = byte_in;
          end
        end
        default: begin
          token_kind = TK_NONE;
        end
      endcase
    end
  end

endmodule

@@ hdl/http_request_header_tokenizer.sv @@
// Top level of the HTTP request header tokenizer: state, configuration and result register.
//
// The block takes one request byte per word on the in_ channel (in_tdata) and
// returns exactly one result word on the out_ channel for every input word.
// in_tlast marks that the source has no more bytes; its data byte is ignored.
// Each result carries the token kind in out_tuser and, in out_tdata, the
// token byte, the verb seen so far, the parse status and the query-abandoned
// flag.
// The result of an accepted byte is registered and shows in the cycle after
// its acceptance. Throughput is one word per cycle while out_tready is high,
// set by the single pass of per-byte logic between parser state and result register.
// The two limit registers are written through cfg_we, cfg_index and cfg_wdata;
// the user must write them only while no words are in flight, as the block does not enforce it.
// Reset clears the parser to the verb phase, the limits to 63 and 191, and
// empties the result register. When the receiver stalls, the result holds
// and in_tready stays high only if that result is taken in the same cycle.
// Once a status other than busy is reached, every later byte yields token
// none with the held status until the next reset.
module http_request_header_tokenizer import htok_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] byte_in
  input  logic                     in_tlast,   // stream_end
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata,  // [7:0] token_byte, [9:8] verb_code,
                                               // [12:10] parse_status, [13] query_abandoned
  output logic [3:0]               out_tuser,  // [3:0] token_kind
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]      cfg_wdata
);

  tok_state_t          st_r;
  tok_state_t          st_nxt;
  logic [CfgWidth-1:0] qkl_r;
  logic [CfgWidth-1:0] qvl_r;
  logic                out_valid_r;
  token_t              kind_r;
  logic [7:0]          tbyte_r;
  verb_t               verb_r;
  status_t             status_r;
  logic                qdead_r;
  token_t              kind_nxt;
  logic [7:0]          tbyte_nxt;
  logic                in_acc;

  htok_step u_step (
    .st                (st_r),
    .byte_in           (in_tdata),
    .stream_end        (in_tlast),
    .query_key_limit   (qkl_r),
    .query_value_limit (qvl_r),
    .st_nxt            (st_nxt),
    .token_kind        (kind_nxt),
    .token_byte        (tbyte_nxt)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StateReset;
      qkl_r <= QueryKeyLimitReset;
      qvl_r <= QueryValueLimitReset;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUERY_KEY_LIMIT:   qkl_r <= cfg_wdata;
          CFG_QUERY_VALUE_LIMIT: qvl_r <= cfg_wdata;
          default: qkl_r <= qkl_r;
        endcase
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= kind_nxt;
      tbyte_r <= tbyte_nxt;
      verb_r <= st_nxt.verb_held;
      status_r <= phase_status(st_nxt.phase);
      qdead_r <= st_nxt.query_dead;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = kind_r;
  assign out_tdata = {2'b00, qdead_r, status_r, verb_r, tbyte_r};

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r)
    else $error("input taken no word while result register was empty");

  a_done_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase >= PH_DONE_OK) |=> (st_r.phase == $past(st_r.phase)))
    else $error("finished parse left its final phase");

  a_accept_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == TK_ACCEPT) |-> (status_r == ST_OK))
    else $error("accept token without done status");

  a_verb_after_verb_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.verb_held != VERB_NONE) |-> (st_r.phase != PH_VERB))
    else $error("verb known while still in verb phase");

  a_busy_no_accept_token: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_BUSY) |-> (kind_r != TK_ACCEPT))
    else $error("accept token while parse still busy");

endmodule
